// File: sv/swdf_pkg.sv
// ----------------------------------------------------------------------------
// swdf_pkg: shared types and constants of the swap walk duplicate finder
// Control word layout, microprogram table, result status codes and beat widths.
// ----------------------------------------------------------------------------
`default_nettype none

package swdf_pkg;

   localparam int ELEM_W       = 9;   // signed element on the request side
   localparam int STORE_W      = 8;   // bits kept per element
   localparam int STATUS_W     = 2;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 16;
   localparam int RSP_PAD_W    = RSP_TDATA_W - STATUS_W - STORE_W;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NONE  = 2'd0,
      STATUS_DUP   = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // read address source of the element store
   typedef enum logic [1:0] {
      RD_NONE,
      RD_POS,
      RD_DATA
   } rd_sel_type;

   // write address and data source of the element store
   typedef enum logic [1:0] {
      WR_NONE,
      WR_LOAD,
      WR_POS,
      WR_SELF
   } wr_sel_type;

   // branch test evaluated in a step
   typedef enum logic [1:0] {
      TEST_LOAD,
      TEST_NONE,
      TEST_SELF,
      TEST_DUP
   } test_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_LOAD      = 3'd0;
   localparam step_type STEP_RD_POS    = 3'd1;
   localparam step_type STEP_CHECK_POS = 3'd2;
   localparam step_type STEP_CHECK_DUP = 3'd3;
   localparam step_type STEP_PLACE     = 3'd4;

   typedef struct packed {
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      test_type   test;
      step_type   next_step;   // taken when the test falls through
      step_type   jump_step;   // taken when the test branches
   } ctl_word_type;

   // microprogram: load, then read slot, compare with position, read target, swap
   function automatic ctl_word_type uc_rom(input step_type step);
      ctl_word_type word;
      begin
         unique case (step)
            STEP_LOAD:      word = '{RD_NONE, WR_LOAD, TEST_LOAD, STEP_LOAD, STEP_RD_POS};
            STEP_RD_POS:    word = '{RD_POS, WR_NONE, TEST_NONE, STEP_CHECK_POS,
                                     STEP_CHECK_POS};
            STEP_CHECK_POS: word = '{RD_DATA, WR_NONE, TEST_SELF, STEP_CHECK_DUP,
                                     STEP_RD_POS};
            STEP_CHECK_DUP: word = '{RD_NONE, WR_POS, TEST_DUP, STEP_PLACE, STEP_LOAD};
            STEP_PLACE:     word = '{RD_NONE, WR_SELF, TEST_NONE, STEP_RD_POS, STEP_RD_POS};
            default:        word = '{RD_NONE, WR_NONE, TEST_NONE, STEP_LOAD, STEP_LOAD};
         endcase
         return word;
      end
   endfunction

endpackage

`default_nettype wire

// File: sv/swap_walk_duplicate_finder.sv
// ----------------------------------------------------------------------------
// swap_walk_duplicate_finder: duplicate search by in-place index swapping
// Loads LENGTH elements, checks their range, then walks the store swapping
// each into the slot it names until a duplicate shows up or all are placed.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per element, in index order, element in req_tdata[8:0].
//   rsp_*  : one beat per set of LENGTH elements: status in rsp_tdata[1:0],
//            duplicate value in rsp_tdata[9:2].
//   Loading takes one element per beat. After the last element the walk
//   runs from an element store with one read and one write port, driven
//   by a microcoded sequencer; a set with an out of range element skips
//   the walk and answers the cycle after its last beat.
//   The result sits in an output register: the next set loads while it
//   waits, only the last element of that set is held off until the earlier
//   result is taken. req_tready is low while the walk runs.
//   Reset (synchronous) empties the set in progress and drops any pending
//   result; the store contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_walk_duplicate_finder #(
   parameter int LENGTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // element[8:0], zero pad[15:9]
   input  wire logic [swdf_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // status[1:0], dup_value[9:2], zero pad[15:10]
   output logic [swdf_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready
);

   localparam int IDX_W = $clog2(LENGTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LENGTH - 1);

   logic [swdf_pkg::STORE_W-1:0] element_store [LENGTH];

   swdf_pkg::ctl_word_type ctl;
   swdf_pkg::step_type     step_ff, step_in;
   logic [IDX_W-1:0]       load_count_ff, load_count_in;
   logic                   range_err_ff, range_err_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [IDX_W-1:0]       target_ff, target_in;
   logic [swdf_pkg::STORE_W-1:0] rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   swdf_pkg::status_type   status_ff, status_in;
   logic [swdf_pkg::STORE_W-1:0] dup_ff, dup_in;

   logic                   load_beat;
   logic                   last_load;
   logic                   elem_bad;
   logic [IDX_W-1:0]       rd_idx;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [swdf_pkg::STORE_W-1:0] wr_data;
   logic                   swap_ok;

   assign ctl       = swdf_pkg::uc_rom(step_ff);
   assign last_load = (load_count_ff == LAST_IDX);
   assign req_tready = (ctl.test == swdf_pkg::TEST_LOAD) && !(last_load && rsp_valid_ff);
   assign load_beat = req_tvalid && req_tready;
   assign elem_bad  = req_tdata[swdf_pkg::ELEM_W-1]
                      || (9'(req_tdata[swdf_pkg::STORE_W-1:0]) >= 9'(LENGTH));
   assign rd_idx    = rd_data_ff[IDX_W-1:0];
   assign swap_ok   = (rd_idx != target_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {swdf_pkg::RSP_PAD_W'(0), dup_ff, status_ff};

   // store port selection from the control word
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = pos_ff;
      unique case (ctl.rd_sel)
         swdf_pkg::RD_POS: begin
            rd_en   = 1'b1;
            rd_addr = pos_ff;
         end
         swdf_pkg::RD_DATA: begin
            rd_en   = 1'b1;
            rd_addr = rd_idx;
         end
         default: begin
            rd_en   = 1'b0;
         end
      endcase

      wr_en   = 1'b0;
      wr_addr = load_count_ff;
      wr_data = req_tdata[swdf_pkg::STORE_W-1:0];
      unique case (ctl.wr_sel)
         swdf_pkg::WR_LOAD: begin
            wr_en   = load_beat;
            wr_addr = load_count_ff;
            wr_data = req_tdata[swdf_pkg::STORE_W-1:0];
         end
         swdf_pkg::WR_POS: begin
            wr_en   = swap_ok;
            wr_addr = pos_ff;
            wr_data = rd_data_ff;
         end
         swdf_pkg::WR_SELF: begin
            wr_en   = 1'b1;
            wr_addr = target_ff;
            wr_data = swdf_pkg::STORE_W'(target_ff);
         end
         default: begin
            wr_en   = 1'b0;
         end
      endcase
   end

   // sequencer branch tests and datapath updates
   always_comb begin
      step_in       = step_ff;
      load_count_in = load_count_ff;
      range_err_in  = range_err_ff;
      pos_in        = pos_ff;
      target_in     = target_ff;
      rsp_valid_in  = rsp_valid_ff;
      status_in     = status_ff;
      dup_in        = dup_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (ctl.test)
         swdf_pkg::TEST_LOAD: begin
            if (load_beat) begin
               if (last_load) begin
                  load_count_in = '0;
                  range_err_in  = 1'b0;
                  if (range_err_ff || elem_bad) begin
                     rsp_valid_in = 1'b1;
                     status_in    = swdf_pkg::STATUS_RANGE;
                     dup_in       = '0;
                  end else begin
                     pos_in  = '0;
                     step_in = ctl.jump_step;
                  end
               end else begin
                  load_count_in = load_count_ff + 1'b1;
                  range_err_in  = range_err_ff || elem_bad;
               end
            end
         end
         swdf_pkg::TEST_SELF: begin
            target_in = rd_idx;
            if (rd_idx == pos_ff) begin
               if (pos_ff == LAST_IDX) begin
                  rsp_valid_in = 1'b1;
                  status_in    = swdf_pkg::STATUS_NONE;
                  dup_in       = '0;
                  step_in      = swdf_pkg::STEP_LOAD;
               end else begin
                  pos_in  = pos_ff + 1'b1;
                  step_in = ctl.jump_step;
               end
            end else begin
               step_in = ctl.next_step;
            end
         end
         swdf_pkg::TEST_DUP: begin
            if (!swap_ok) begin
               rsp_valid_in = 1'b1;
               status_in    = swdf_pkg::STATUS_DUP;
               dup_in       = swdf_pkg::STORE_W'(target_ff);
               step_in      = ctl.jump_step;
            end else begin
               step_in = ctl.next_step;
            end
         end
         default: begin
            step_in = ctl.next_step;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= swdf_pkg::STEP_LOAD;
         load_count_ff <= '0;
         range_err_ff  <= 1'b0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         load_count_ff <= load_count_in;
         range_err_ff  <= range_err_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      target_ff <= target_in;
      status_ff <= status_in;
      dup_ff    <= dup_in;
   end

   // element store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         element_store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= element_store[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: sv/swdf_checker.sv
// ----------------------------------------------------------------------------
// swdf_checker: port-level checks of the swap walk duplicate finder
// Checks result hold, legal status, a clean payload and no result after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module swdf_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic [swdf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == swdf_pkg::STATUS_NONE
                      || rsp_tdata[1:0] == swdf_pkg::STATUS_DUP
                      || rsp_tdata[1:0] == swdf_pkg::STATUS_RANGE))
      else $error("illegal status code");

   a_dup_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != swdf_pkg::STATUS_DUP |-> rsp_tdata[9:2] == 8'd0)
      else $error("duplicate value set without a duplicate");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind swap_walk_duplicate_finder swdf_checker u_swdf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
